// ----- rtl/rmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Reed-Muller codec package
// Shared types, codes and constant tables for the RM(r,m) encoder/decoder.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int MAX_VARS  = 6;
  localparam int DATA_W    = 1 << MAX_VARS;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_ORDER     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIABLE_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] CODE_ORDER_RST     = 3'd1;
  localparam logic [CFG_W-1:0] VARIABLE_COUNT_RST = 3'd3;

  typedef logic [5:0]           row_idx_t;
  typedef row_idx_t [0:63]      row_map_t;
  typedef row_map_t [0:7]       row_tab_t;
  typedef logic [6:0]           cnt_t;
  typedef cnt_t [0:7]           cnt_row_t;
  typedef cnt_row_t [0:7]       cnt_tab_t;

  // Payload carried down the pipeline alongside each valid bit.
  typedef struct packed {
    logic              cmd;
    logic [2:0]        m;
    logic [2:0]        r;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] res;
    logic              fail;
  } pipe_t;

  function automatic logic [2:0] popcnt6(input logic [5:0] x);
    logic [2:0] c;
    c = 3'd0;
    for (int i = 0; i < 6; i++) c = c + 3'(x[i]);
    return c;
  endfunction

  // A monomial is held as the set of codeword position bits it constrains.
  // Lexicographic order of variable lists is descending order of the mask
  // with variable one in the top bit, so rows are enumerated that way.
  function automatic row_tab_t build_row_of();
    row_tab_t t;
    int       idx;
    t = '0;
    for (int m = 1; m <= MAX_VARS; m++) begin
      idx = 0;
      for (int d = 0; d <= m; d++) begin
        for (int v = 63; v >= 0; v--) begin
          if (popcnt6(6'(v)) == 3'(d) && ((v >> (6 - m)) << (6 - m)) == v) begin
            t[m][6'(v >> (6 - m))] = 6'(idx);
            idx++;
          end
        end
      end
    end
    return t;
  endfunction

  function automatic row_tab_t build_bm_of();
    row_tab_t t;
    int       idx;
    t = '0;
    for (int m = 1; m <= MAX_VARS; m++) begin
      idx = 0;
      for (int d = 0; d <= m; d++) begin
        for (int v = 63; v >= 0; v--) begin
          if (popcnt6(6'(v)) == 3'(d) && ((v >> (6 - m)) << (6 - m)) == v) begin
            t[m][6'(idx)] = 6'(v >> (6 - m));
            idx++;
          end
        end
      end
    end
    return t;
  endfunction

  function automatic cnt_tab_t build_k_cnt();
    cnt_tab_t t;
    int       c;
    t = '0;
    for (int m = 1; m <= MAX_VARS; m++) begin
      for (int r = 0; r < 8; r++) begin
        c = 0;
        for (int b = 0; b < 64; b++) begin
          if ((b >> m) == 0 && int'(popcnt6(6'(b))) <= r) c++;
        end
        t[m][r] = 7'(c);
      end
    end
    return t;
  endfunction

  localparam row_tab_t ROW_OF = build_row_of();
  localparam row_tab_t BM_OF  = build_bm_of();
  localparam cnt_tab_t K_CNT  = build_k_cnt();

  // Positions below the codeword length n = 2^m.
  function automatic logic [DATA_W-1:0] len_mask(input logic [2:0] m);
    logic [DATA_W-1:0] nm;
    for (int p = 0; p < DATA_W; p++) nm[p] = ((7'(p) >> m) == 7'd0);
    return nm;
  endfunction

  // Generator row of a monomial: one where all its position bits are zero.
  function automatic logic [DATA_W-1:0] gen_pat(input logic [5:0] bm);
    logic [DATA_W-1:0] g;
    for (int p = 0; p < DATA_W; p++) g[p] = ((6'(p) & bm) == 6'd0);
    return g;
  endfunction

  // Monomials whose generator row covers position p.
  function automatic logic [DATA_W-1:0] col_mask(input logic [5:0] p);
    logic [DATA_W-1:0] c;
    for (int b = 0; b < DATA_W; b++) c[b] = ((6'(b) & p) == 6'd0);
    return c;
  endfunction

  // Number of characteristic checks of monomial bm that come out odd. The
  // word is XOR-folded over the monomial's bits so each surviving position
  // holds the parity of one subcube.
  function automatic cnt_t vote_ones(input logic [DATA_W-1:0] cur,
                                     input logic [5:0] bm);
    logic [DATA_W-1:0] f;
    cnt_t              c;
    f = cur;
    for (int b = 0; b < 6; b++) begin
      if (bm[b]) f = f ^ (f >> (1 << b));
    end
    c = '0;
    for (int p = 0; p < DATA_W; p++) begin
      if ((6'(p) & bm) == 6'd0) c = c + 7'(f[p]);
    end
    return c;
  endfunction

endpackage

// ----- rtl/rmc_if.sv -----
// ----------------------------------------------------------------------------
// Reed-Muller codec channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface rmc_in_if;
  import rmc_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] data_word;
  modport source (output valid, cmd, data_word, input ready);
  modport sink   (input valid, cmd, data_word, output ready);
endinterface

interface rmc_out_if;
  import rmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_word;
  logic              decode_failed;
  modport source (output valid, result_word, decode_failed, input ready);
  modport sink   (input valid, result_word, decode_failed, output ready);
endinterface

interface rmc_cfg_if;
  import rmc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/rmc_front.sv -----
// ----------------------------------------------------------------------------
// Reed-Muller codec front stage
// Clamps the configuration, masks the word and performs the encode.
// ----------------------------------------------------------------------------
module rmc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rmc_pkg::CFG_W-1:0]  code_order,
  input  logic [rmc_pkg::CFG_W-1:0]  variable_count,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [rmc_pkg::DATA_W-1:0] in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rmc_pkg::pipe_t             out_pay
);
  import rmc_pkg::*;

  logic [2:0]        m;
  logic [2:0]        r;
  logic [DATA_W-1:0] nm;
  logic [DATA_W-1:0] enc;
  cnt_t              k;
  logic              valid_r;
  pipe_t             pay_r;
  pipe_t             pay_nxt;

  always_comb begin
    if (variable_count == 3'd0) begin
      m = 3'd1;
    end else if (variable_count > 3'(MAX_VARS)) begin
      m = 3'(MAX_VARS);
    end else begin
      m = variable_count;
    end
    r  = (code_order > m) ? m : code_order;
    nm = len_mask(m);
    k  = K_CNT[m][r];
    enc = '0;
    for (int j = 0; j < DATA_W; j++) begin
      if (in_data[j] && (7'(j) < k)) enc = enc ^ gen_pat(BM_OF[m][j]);
    end
    pay_nxt.cmd  = in_cmd;
    pay_nxt.m    = m;
    pay_nxt.r    = r;
    pay_nxt.fail = 1'b0;
    if (in_cmd == CMD_DECODE) begin
      pay_nxt.cur = in_data & nm;
      pay_nxt.res = '0;
    end else begin
      pay_nxt.cur = '0;
      pay_nxt.res = enc & nm;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_pay   = pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pay_r <= pay_nxt;
    end
  end

endmodule

// ----- rtl/rmc_deg_stage.sv -----
// ----------------------------------------------------------------------------
// Reed-Muller codec degree stage
// Majority votes for every monomial of one degree, then removes their rows.
// ----------------------------------------------------------------------------
module rmc_deg_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [2:0]     deg,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmc_pkg::pipe_t in_pay,
  output logic           out_valid,
  input  logic           out_ready,
  output rmc_pkg::pipe_t out_pay
);
  import rmc_pkg::*;

  logic [DATA_W-1:0] dec;
  logic [DATA_W-1:0] tie_vec;
  pipe_t             a_pay_nxt;
  pipe_t             a_pay_r;
  logic [DATA_W-1:0] a_dec_r;
  logic              a_valid_r;
  logic              a_ready;
  logic [DATA_W-1:0] sub;
  pipe_t             b_pay_nxt;
  pipe_t             b_pay_r;
  logic              b_valid_r;
  logic              b_ready;

  // One voter per position-bit mask; those of other degrees fold away.
  for (genvar g = 0; g < DATA_W; g++) begin : g_vote
    logic       active;
    logic [7:0] twice;
    logic [7:0] total;
    assign active = (in_pay.cmd == CMD_DECODE) && (popcnt6(6'(g)) == deg) &&
                    ((6'(g) >> in_pay.m) == 6'd0) && (deg <= in_pay.r);
    assign twice      = {vote_ones(in_pay.cur, 6'(g)), 1'b0};
    assign total      = 8'd1 << (in_pay.m - deg);
    assign dec[g]     = active && (twice > total);
    assign tie_vec[g] = active && (twice == total);
  end

  always_comb begin
    a_pay_nxt      = in_pay;
    a_pay_nxt.fail = in_pay.fail | (|tie_vec);
    for (int b = 0; b < DATA_W; b++) begin
      if (dec[b]) a_pay_nxt.res[ROW_OF[in_pay.m][b]] = 1'b1;
    end
  end

  always_comb begin
    for (int p = 0; p < DATA_W; p++) sub[p] = ^(a_dec_r & col_mask(6'(p)));
    b_pay_nxt     = a_pay_r;
    b_pay_nxt.cur = a_pay_r.cur ^ (sub & len_mask(a_pay_r.m));
  end

  assign b_ready   = !b_valid_r || out_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_ready  = a_ready;
  assign out_valid = b_valid_r;
  assign out_pay   = b_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_valid;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_pay_r <= a_pay_nxt;
      a_dec_r <= dec;
    end
    if (a_valid_r && b_ready) begin
      b_pay_r <= b_pay_nxt;
    end
  end

endmodule

// ----- rtl/reed_muller_codec_top.sv -----
// Pipeline: an accepted item passes the front stage and then two stages for
// each of the seven degrees before its result appears.
// Throughput: one item per cycle; each stage holds its item under stall.
// Reset: synchronous, active low; empties the pipeline and sets the order to
// one and the variable count to three. Register writes are always accepted.
// ----------------------------------------------------------------------------
// Reed-Muller codec top level
// RM(r,m) encoder and majority-logic decoder as a fifteen-stage pipeline.
// ----------------------------------------------------------------------------
module reed_muller_codec_top (
  input  logic       clk,
  input  logic       rst_n,
  rmc_cfg_if.sink    cfg_port,
  rmc_in_if.sink     in_port,
  rmc_out_if.source  out_port
);
  import rmc_pkg::*;

  localparam int N_DEG = MAX_VARS + 1;

  logic [CFG_W-1:0] code_order_r;
  logic [CFG_W-1:0] variable_count_r;
  pipe_t            st_pay   [0:N_DEG];
  logic             st_valid [0:N_DEG];
  logic             st_ready [0:N_DEG];

  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_order_r     <= CODE_ORDER_RST;
      variable_count_r <= VARIABLE_COUNT_RST;
    end else if (cfg_port.valid) begin
      unique case (cfg_port.index)
        CFG_CODE_ORDER:     code_order_r     <= cfg_port.data;
        CFG_VARIABLE_COUNT: variable_count_r <= cfg_port.data;
        default: ;
      endcase
    end
  end

  rmc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .code_order     (code_order_r),
    .variable_count (variable_count_r),
    .in_valid       (in_port.valid),
    .in_ready       (in_port.ready),
    .in_cmd         (in_port.cmd),
    .in_data        (in_port.data_word),
    .out_valid      (st_valid[0]),
    .out_ready      (st_ready[0]),
    .out_pay        (st_pay[0])
  );

  // Degrees are decided from the highest down.
  for (genvar i = 0; i < N_DEG; i++) begin : g_deg
    rmc_deg_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .deg       (3'(MAX_VARS - i)),
      .in_valid  (st_valid[i]),
      .in_ready  (st_ready[i]),
      .in_pay    (st_pay[i]),
      .out_valid (st_valid[i+1]),
      .out_ready (st_ready[i+1]),
      .out_pay   (st_pay[i+1])
    );
  end

  assign st_ready[N_DEG]        = out_port.ready;
  assign out_port.valid         = st_valid[N_DEG];
  assign out_port.decode_failed = st_pay[N_DEG].fail;
  assign out_port.result_word   = st_pay[N_DEG].fail ? '0 : st_pay[N_DEG].res;

`ifndef SYNTH
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid && out_port.decode_failed |-> out_port.result_word == '0)
    else $error("failed decode item carries a non-zero result");

  a_encode_ok: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid[N_DEG] && (st_pay[N_DEG].cmd == CMD_ENCODE) |-> !st_pay[N_DEG].fail)
    else $error("encode item flagged as failed");

  a_front_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid[0] |-> (st_pay[0].r <= st_pay[0].m) && (st_pay[0].m != 3'd0))
    else $error("configuration not clamped in front stage");
`endif

endmodule
